// File: rtl/ats_pkg.sv
// Shared types and constants of the assembly token scanner.
package ats_pkg;

	// Fixed widths of the request and result fields.
	localparam int CHAR_W  = 8;
	localparam int KIND_W  = 4;
	localparam int START_W = 32;
	localparam int LEN_W   = 16;
	localparam int LINE_W  = 24;

	// Default configuration of the top level.
	localparam int OFFSET_BITS_DEF = 32;
	localparam int LENGTH_BITS_DEF = 16;

	// Depth of the result queue; a power of two, at least two.
	localparam int FIFO_DEPTH = 4;

	localparam logic [LINE_W-1:0] LINE_MAX = '1;

	// Token kinds as reported on the result channel.
	typedef enum logic [KIND_W-1:0] {
		K_COMMA     = 4'd0,
		K_DIRECTIVE = 4'd1,
		K_QUOTED    = 4'd2,
		K_WORDLIST  = 4'd3,
		K_REGISTER  = 4'd4,
		K_LABELDEF  = 4'd5,
		K_IDENT     = 4'd6,
		K_IMMEDIATE = 4'd7,
		K_ERROR     = 4'd8,
		K_EOF       = 4'd9
	} tok_kind_t;

	// One source request.
	typedef struct packed {
		logic [CHAR_W-1:0] char_byte;
		logic              end_of_input;
	} char_item_t;

	// One result item.
	typedef struct packed {
		logic [KIND_W-1:0]  token_kind;
		logic [START_W-1:0] start_offset;
		logic [LEN_W-1:0]   lexeme_length;
		logic [LINE_W-1:0]  line_number;
		logic               last_of_run;
	} token_item_t;

	// Write strobes from the scanner into the result queue.
	typedef struct packed {
		logic wr0;
		logic wr1;
	} fifo_push_t;

	// Queue status seen by the scanner.
	typedef struct packed {
		logic room_two;
	} fifo_stat_t;

endpackage

// File: rtl/ats_char_if.sv
// Source byte channel of the token scanner.
interface ats_char_if;
	logic                valid;
	logic                ready;
	ats_pkg::char_item_t data;

	modport source (output valid, output data, input ready);
	modport sink (input valid, input data, output ready);
endinterface

// File: rtl/ats_token_if.sv
// Token result channel of the token scanner.
interface ats_token_if;
	logic                 valid;
	logic                 ready;
	ats_pkg::token_item_t data;

	modport source (output valid, output data, input ready);
	modport sink (input valid, input data, output ready);
endinterface

// File: rtl/assembly_token_scanner.sv
// Path: an accepted request is held in the input register, and its results are written
// into the result queue, whose head drives the result port.
// Throughput: one request per cycle while the queue has room for two results; a request
// that yields two results shares the single result port of the queue, so such streams run slower.
// Reset: asynchronous; mode idle, position 0, token start 0, line 1, queue empty.
// After the end mark further bytes give nothing and each end mark gives one eof.
module assembly_token_scanner #(
	parameter int OFFSET_BITS = ats_pkg::OFFSET_BITS_DEF,
	parameter int LENGTH_BITS = ats_pkg::LENGTH_BITS_DEF
) (
	input logic       clk,
	input logic       arst_n,
	ats_char_if.sink  char_in,
	ats_token_if.source token_out
);

	localparam int CHAR_W  = ats_pkg::CHAR_W;
	localparam int START_W = ats_pkg::START_W;
	localparam int LEN_W   = ats_pkg::LEN_W;
	localparam int LINE_W  = ats_pkg::LINE_W;

	localparam logic [CHAR_W-1:0] C_NL    = 8'h0A;
	localparam logic [CHAR_W-1:0] C_SEMI  = 8'h3B;
	localparam logic [CHAR_W-1:0] C_COMMA = 8'h2C;
	localparam logic [CHAR_W-1:0] C_DOT   = 8'h2E;
	localparam logic [CHAR_W-1:0] C_QUOTE = 8'h22;
	localparam logic [CHAR_W-1:0] C_LBR   = 8'h7B;
	localparam logic [CHAR_W-1:0] C_RBR   = 8'h7D;
	localparam logic [CHAR_W-1:0] C_DOLL  = 8'h24;
	localparam logic [CHAR_W-1:0] C_UNDER = 8'h5F;
	localparam logic [CHAR_W-1:0] C_COLON = 8'h3A;

	typedef enum logic [2:0] {
		M_IDLE,
		M_COMMENT,
		M_DIRECTIVE,
		M_QUOTED,
		M_WORDLIST,
		M_REGISTER,
		M_WORD,
		M_IMMEDIATE
	} mode_t;

	// Outcome of scanning one byte from idle mode.
	typedef struct packed {
		mode_t                  mode;
		logic                   load_start;
		logic [OFFSET_BITS-1:0] start;
		logic                   comma;
	} idle_res_t;

	function automatic logic is_ws(input logic [CHAR_W-1:0] c);
		return (c == 8'h20) || ((c >= 8'h09) && (c <= 8'h0D));
	endfunction

	function automatic logic is_alpha(input logic [CHAR_W-1:0] c);
		return ((c >= 8'h61) && (c <= 8'h7A)) || ((c >= 8'h41) && (c <= 8'h5A));
	endfunction

	function automatic logic is_alnum(input logic [CHAR_W-1:0] c);
		return is_alpha(c) || ((c >= 8'h30) && (c <= 8'h39));
	endfunction

	function automatic idle_res_t idle_decode(input logic [CHAR_W-1:0] c,
			input logic [OFFSET_BITS-1:0] cur);
		idle_res_t r;
		r.mode       = M_IDLE;
		r.load_start = 1'b0;
		r.start      = cur;
		r.comma      = 1'b0;
		if (is_ws(c)) begin
			r.mode = M_IDLE;
		end else if (c == C_SEMI) begin
			r.mode = M_COMMENT;
		end else if (c == C_COMMA) begin
			r.comma = 1'b1;
		end else if (c == C_DOT || c == C_QUOTE || c == C_LBR) begin
			// The opening delimiter is not part of the lexeme.
			r.mode       = (c == C_DOT) ? M_DIRECTIVE :
					(c == C_QUOTE) ? M_QUOTED : M_WORDLIST;
			r.load_start = 1'b1;
			r.start      = OFFSET_BITS'(cur + 1'b1);
		end else if (c == C_DOLL) begin
			r.mode       = M_REGISTER;
			r.load_start = 1'b1;
		end else if (is_alpha(c) || c == C_UNDER) begin
			r.mode       = M_WORD;
			r.load_start = 1'b1;
		end else begin
			r.mode       = M_IMMEDIATE;
			r.load_start = 1'b1;
		end
		return r;
	endfunction

	// Input register and scanner state.
	logic                   valid_s1;
	ats_pkg::char_item_t    item_s1;
	mode_t                  mode_q;
	logic [OFFSET_BITS-1:0] pos_q;
	logic [OFFSET_BITS-1:0] start_q;
	logic [LINE_W-1:0]      line_q;
	logic                   done_q;

	mode_t                  mode_d;
	logic [OFFSET_BITS-1:0] pos_d;
	logic [OFFSET_BITS-1:0] start_d;
	logic [LINE_W-1:0]      line_d;
	logic                   done_d;

	logic                   wr0_c;
	logic                   wr1_c;
	ats_pkg::token_item_t   r0;
	ats_pkg::token_item_t   r1;
	ats_pkg::fifo_push_t    push;
	ats_pkg::fifo_stat_t    stat;
	logic                   advance;
	logic                   accept;
	idle_res_t              idl;
	logic [CHAR_W-1:0]      c;
	logic [OFFSET_BITS-1:0] span;
	logic [LENGTH_BITS-1:0] len_sat;
	logic [LEN_W-1:0]       tok_len;
	logic [START_W-1:0]     tok_start;
	logic [START_W-1:0]     cur_start;

	assign advance       = valid_s1 && stat.room_two;
	assign char_in.ready = !valid_s1 || advance;
	assign accept        = char_in.valid && char_in.ready;

	// Lexeme length of the current token, saturated.
	assign span = OFFSET_BITS'(pos_q - start_q);
	if (OFFSET_BITS > LENGTH_BITS) begin : g_sat
		assign len_sat = (|span[OFFSET_BITS-1:LENGTH_BITS]) ? '1 : span[LENGTH_BITS-1:0];
	end else begin : g_nosat
		assign len_sat = LENGTH_BITS'(span);
	end
	assign tok_len   = LEN_W'(len_sat);
	assign tok_start = START_W'(start_q);
	assign cur_start = START_W'(pos_q);

	assign c   = item_s1.char_byte;
	assign idl = idle_decode(c, pos_q);

	// Next state and the results of the request held in stage one.
	always_comb begin
		mode_d  = mode_q;
		pos_d   = pos_q;
		start_d = start_q;
		line_d  = line_q;
		done_d  = done_q;
		wr0_c   = 1'b0;
		wr1_c   = 1'b0;
		r0.token_kind    = ats_pkg::K_EOF;
		r0.start_offset  = tok_start;
		r0.lexeme_length = tok_len;
		r1.token_kind    = ats_pkg::K_COMMA;
		r1.start_offset  = cur_start;
		r1.lexeme_length = LEN_W'(1);

		if (item_s1.end_of_input) begin
			// End mark: error for an open token, then eof.
			mode_d = M_IDLE;
			done_d = 1'b1;
			wr0_c  = 1'b1;
			if (!done_q && mode_q != M_IDLE && mode_q != M_COMMENT) begin
				r0.token_kind    = ats_pkg::K_ERROR;
				wr1_c            = 1'b1;
				r1.token_kind    = ats_pkg::K_EOF;
				r1.start_offset  = cur_start;
				r1.lexeme_length = '0;
			end else begin
				r0.token_kind    = ats_pkg::K_EOF;
				r0.start_offset  = cur_start;
				r0.lexeme_length = '0;
			end
		end else if (!done_q) begin
			pos_d = OFFSET_BITS'(pos_q + 1'b1);
			if (c == C_NL && line_q != ats_pkg::LINE_MAX) begin
				line_d = LINE_W'(line_q + 1'b1);
			end
			unique case (mode_q)
				M_IDLE: begin
					mode_d = idl.mode;
					if (idl.load_start) begin
						start_d = idl.start;
					end
					wr0_c            = idl.comma;
					r0.token_kind    = ats_pkg::K_COMMA;
					r0.start_offset  = cur_start;
					r0.lexeme_length = LEN_W'(1);
				end
				M_COMMENT: begin
					if (c == C_NL) begin
						mode_d = M_IDLE;
					end
				end
				M_DIRECTIVE: begin
					if (is_ws(c)) begin
						wr0_c         = 1'b1;
						r0.token_kind = ats_pkg::K_DIRECTIVE;
						mode_d        = M_IDLE;
					end
				end
				M_QUOTED: begin
					if (c == C_QUOTE) begin
						wr0_c         = 1'b1;
						r0.token_kind = ats_pkg::K_QUOTED;
						mode_d        = M_IDLE;
					end
				end
				M_WORDLIST: begin
					if (c == C_RBR) begin
						wr0_c         = 1'b1;
						r0.token_kind = ats_pkg::K_WORDLIST;
						mode_d        = M_IDLE;
					end
				end
				M_REGISTER: begin
					// The terminator is scanned again from idle.
					if (is_ws(c) || c == C_COMMA) begin
						wr0_c         = 1'b1;
						r0.token_kind = ats_pkg::K_REGISTER;
						mode_d        = idl.mode;
						wr1_c         = idl.comma;
					end
				end
				M_WORD: begin
					// The terminator is consumed here.
					if (!(is_alnum(c) || c == C_UNDER)) begin
						wr0_c         = 1'b1;
						r0.token_kind = (c == C_COLON) ? ats_pkg::K_LABELDEF :
								ats_pkg::K_IDENT;
						mode_d        = M_IDLE;
					end
				end
				M_IMMEDIATE: begin
					// The terminator is scanned again from idle.
					if (!is_alnum(c)) begin
						wr0_c         = 1'b1;
						r0.token_kind = ats_pkg::K_IMMEDIATE;
						mode_d        = idl.mode;
						if (idl.load_start) begin
							start_d = idl.start;
						end
						wr1_c = idl.comma;
					end
				end
			endcase
		end

		r0.line_number = line_d;
		r1.line_number = line_d;
		r0.last_of_run = !wr1_c;
		r1.last_of_run = 1'b1;
	end

	assign push.wr0 = advance && wr0_c;
	assign push.wr1 = advance && wr1_c;

	// Input register.
	always_ff @(posedge clk) begin
		if (accept) begin
			item_s1 <= char_in.data;
		end
	end

	// Stage valid and scanner state.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			mode_q   <= M_IDLE;
			pos_q    <= '0;
			start_q  <= '0;
			line_q   <= LINE_W'(1);
			done_q   <= 1'b0;
		end else begin
			if (accept) begin
				valid_s1 <= 1'b1;
			end else if (advance) begin
				valid_s1 <= 1'b0;
			end
			if (advance) begin
				mode_q  <= mode_d;
				pos_q   <= pos_d;
				start_q <= start_d;
				line_q  <= line_d;
				done_q  <= done_d;
			end
		end
	end

	// Queue between the scanner and the result channel.
	ats_result_fifo #(
		.DEPTH(ats_pkg::FIFO_DEPTH)
	) u_fifo (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.d0        (r0),
		.d1        (r1),
		.stat      (stat),
		.token_out (token_out)
	);

endmodule

// File: rtl/ats_result_fifo.sv
// Result queue: takes up to two results a cycle and presents one at a time.
module ats_result_fifo #(
	parameter int DEPTH = ats_pkg::FIFO_DEPTH
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  ats_pkg::fifo_push_t  push,
	input  ats_pkg::token_item_t d0,
	input  ats_pkg::token_item_t d1,
	output ats_pkg::fifo_stat_t  stat,
	ats_token_if.source          token_out
);

	localparam int PTR_W = $clog2(DEPTH);
	localparam int CNT_W = $clog2(DEPTH + 1);

	ats_pkg::token_item_t mem_q [DEPTH];
	logic [PTR_W-1:0] wr_ptr_q;
	logic [PTR_W-1:0] rd_ptr_q;
	logic [CNT_W-1:0] count_q;
	logic [CNT_W-1:0] count_after_pop;
	logic [PTR_W-1:0] wr_ptr_nxt;
	logic             pop;

	// Head of the queue drives the result channel.
	assign token_out.valid = (count_q != '0);
	assign token_out.data  = mem_q[rd_ptr_q];
	assign pop             = token_out.valid && token_out.ready;

	// Room for two new results once this cycle's pop is counted.
	assign count_after_pop = count_q - CNT_W'(pop);
	assign stat.room_two   = (count_after_pop <= CNT_W'(DEPTH - 2));
	assign wr_ptr_nxt      = PTR_W'(wr_ptr_q + 1'b1);

	// Storage for the queued results.
	always_ff @(posedge clk) begin
		if (push.wr0) begin
			mem_q[wr_ptr_q] <= d0;
		end
		if (push.wr1) begin
			mem_q[wr_ptr_nxt] <= d1;
		end
	end

	// Pointers and fill count.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			wr_ptr_q <= PTR_W'(wr_ptr_q + PTR_W'(push.wr0) + PTR_W'(push.wr1));
			if (pop) begin
				rd_ptr_q <= PTR_W'(rd_ptr_q + 1'b1);
			end
			count_q <= CNT_W'(count_after_pop + CNT_W'(push.wr0) + CNT_W'(push.wr1));
		end
	end

endmodule
